/* design/wrs_pkg.sv */
package wrs_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_PACKETS_DEF = 1024;
    localparam int WINDOW_MAX_DEF  = 16;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 64;
    localparam int IDX_W    = 10;
    localparam int ATT_W    = 8;
    localparam int KIND_W   = 2;
    localparam int BYTES_W  = 16;
    localparam int MTU_W    = 16;
    localparam int FLOW_W   = 26;
    localparam int WLIM_W   = 5;
    localparam int PERIOD_W = 32;
    localparam int LIMIT_W  = 8;
    localparam int MARK_W   = 2;
    localparam int ENTRY_W  = MARK_W + ATT_W;

    // results per event
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = 5;

    // ceiling divide of flow by mtu, one quotient bit a cycle
    localparam int DIV_NUM_W = FLOW_W + 1;
    localparam int DIV_CNT_W = 5;

    // register port
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_SEL_W = 3;

    localparam logic [REG_SEL_W-1:0] REG_MTU     = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_FLOW    = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_WINDOW  = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_PACING  = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_TIMEOUT = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_LIMIT   = 3'd5;

    localparam logic [MTU_W-1:0]    MTU_RST     = 16'd1500;
    localparam logic [FLOW_W-1:0]   FLOW_RST    = 26'd1500;
    localparam logic [WLIM_W-1:0]   WLIM_RST    = 5'd16;
    localparam logic [PERIOD_W-1:0] PACING_RST  = 32'd0;
    localparam logic [PERIOD_W-1:0] TIMEOUT_RST = 32'd1000000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 8'd8;

    // event kinds
    localparam logic [FUNC_W-1:0] FUNC_WAKE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TIMER = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAKE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   send_index;
        logic [BYTES_W-1:0] send_bytes;
        logic [ATT_W-1:0]   send_attempt;
        logic [TIME_W-1:0]  event_time;
        logic               is_retransmit;
    } t_result;

    // commands from the controller
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic ack_upd;
        logic tmo_fail;
        logic tmo_retry;
        logic tail_sub;
        logic ring_push;
        logic wake_emit;
        logic pop;
        logic take_seq;
        logic send_emit;
        logic flush;
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic clr_done;
        logic idx_ok;
        logic acked;
        logic att_match;
        logic failed;
        logic fail_now;
        logic ring_room;
        logic tail_ge;
        logic win_full;
        logic at_cap;
        logic paced;
        logic wake_pending;
        logic ring_empty;
        logic seq_done;
        logic from_ring;
        logic can_emit;
        logic pend_valid;
        logic can_flush;
    } t_stat;

endpackage

/* design/wrs_div.sv */
module wrs_div
    import wrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MTU_W-1:0]     i_mtu,
    input  logic [FLOW_W-1:0]    i_flow,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_load;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [MTU_W-1:0]     r_rem;
    logic [MTU_W-1:0]     r_div;
    logic [MTU_W-1:0]     mtu_eff;
    logic [MTU_W:0]       rem_sh;
    logic                 q_bit;

    // zero mtu counts as one
    assign mtu_eff = (i_mtu == '0) ? MTU_W'(1) : i_mtu;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
    end

    // control: reload after reset and on start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b1;
            r_cnt  <= '0;
        end else if (r_load || i_start) begin
            r_load <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // numerator shifts out, quotient shifts in
    always_ff @(posedge i_clk) begin
        if (r_load || i_start) begin
            r_num <= DIV_NUM_W'(i_flow) + DIV_NUM_W'(mtu_eff) - DIV_NUM_W'(1);
            r_rem <= '0;
            r_div <= mtu_eff;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[DIV_NUM_W-2:0], q_bit};
            r_rem <= q_bit ? MTU_W'(rem_sh - {1'b0, r_div}) : MTU_W'(rem_sh);
        end
    end

    assign o_busy = r_load | i_start | (r_cnt != '0);
    assign o_quot = r_num;

endmodule

/* design/wrs_datapath.sv */
module wrs_datapath
    import wrs_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [TIME_W-1:0]    i_now_time,
    input  logic [IDX_W-1:0]     i_packet_index,
    input  logic [ATT_W-1:0]     i_timer_attempt,
    input  logic [MTU_W-1:0]     i_mtu,
    input  logic [FLOW_W-1:0]    i_flow,
    input  logic [WLIM_W-1:0]    i_window_limit,
    input  logic [PERIOD_W-1:0]  i_pacing,
    input  logic [PERIOD_W-1:0]  i_timeout,
    input  logic [LIMIT_W-1:0]   i_attempt_limit,
    input  logic [DIV_NUM_W-1:0] i_quot,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_result              o_out,
    output logic                 o_out_last
);

    localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // packet store: {in flight, acked, attempt count}
    logic [ENTRY_W-1:0] mem [MAX_PACKETS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [AW-1:0]      r_clr_addr;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [FUNC_W-1:0]  r_func;
    logic [TIME_W-1:0]  r_now;
    logic [ATT_W-1:0]   r_tatt;
    logic [IDX_W-1:0]   r_cur_idx;
    logic               r_from_ring;

    logic [IDX_W-1:0]   r_ring [WINDOW_MAX];
    logic [RW-1:0]      r_head;
    logic [WW-1:0]      r_count;
    logic [WW:0]        r_tail;

    logic [CW-1:0]      r_next_seq;
    logic [WW-1:0]      r_outstanding;
    logic [TIME_W-1:0]  r_nst;
    logic               r_wake_pending;
    logic               r_failed;
    logic [CAP_W-1:0]   r_n;
    logic [FLOW_W-1:0]  r_prod;

    logic               r_pend_valid;
    t_result            r_pend;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_out_last;

    logic [CW-1:0]      pc;
    logic [WW-1:0]      win;
    logic [31:0]        w_tmp;
    logic [MTU_W-1:0]   mtu_eff;
    logic [FLOW_W:0]    rem;
    logic [BYTES_W-1:0] bytes;
    logic [ATT_W-1:0]   cnt;
    logic               acked;
    logic               flight;
    logic               emit_any;
    logic               out_load_ok;
    logic               leave_dec;
    t_result            new_rec;

    assign cnt    = r_rd_data[ATT_W-1:0];
    assign acked  = r_rd_data[ATT_W];
    assign flight = r_rd_data[ATT_W+1];

    // packet count and window from the registers
    always_comb begin
        pc = (32'(i_quot) > 32'(MAX_PACKETS)) ? CW'(MAX_PACKETS) : CW'(i_quot);
        w_tmp = 32'(i_window_limit);
        if (w_tmp > 32'(pc)) w_tmp = 32'(pc);
        if (w_tmp > 32'(WINDOW_MAX)) w_tmp = 32'(WINDOW_MAX);
        if (w_tmp == 32'd0) w_tmp = 32'd1;
        win = WW'(w_tmp);
    end

    // payload size of the current packet
    assign mtu_eff = (i_mtu == '0) ? MTU_W'(1) : i_mtu;
    always_comb begin
        rem = {1'b0, i_flow} - {1'b0, r_prod};
        if (r_prod > i_flow) begin
            bytes = mtu_eff;
        end else if (rem < (FLOW_W+1)'(mtu_eff)) begin
            bytes = BYTES_W'(rem);
        end else begin
            bytes = mtu_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= FLOW_W'(r_cur_idx) * FLOW_W'(mtu_eff);
    end

    // store updates
    assign leave_dec = flight && (r_outstanding != '0);
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rd_data;
        if (i_cmd.ack_upd) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, 1'b1, cnt};
        end else if (i_cmd.tmo_fail) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, acked, cnt};
        end else if (i_cmd.tmo_retry) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, acked, cnt + ATT_W'(1)};
        end else if (i_cmd.send_emit) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, acked, cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (mem_we) begin
            mem[AW'(r_cur_idx)] <= mem_wdata;
        end
        r_rd_data <= mem[AW'(r_cur_idx)];
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // result record for the current emit
    always_comb begin
        new_rec = '0;
        if (i_cmd.wake_emit) begin
            new_rec.kind       = KIND_WAKE;
            new_rec.event_time = r_nst;
        end else if (i_cmd.tmo_fail) begin
            new_rec.kind = KIND_FAIL;
        end else begin
            new_rec.kind          = KIND_SEND;
            new_rec.send_index    = r_cur_idx;
            new_rec.send_bytes    = bytes;
            new_rec.send_attempt  = cnt;
            new_rec.event_time    = r_now + TIME_W'(i_timeout);
            new_rec.is_retransmit = (cnt != '0);
        end
    end

    assign emit_any    = i_cmd.wake_emit | i_cmd.tmo_fail | i_cmd.send_emit;
    assign out_load_ok = !r_out_valid || !i_out_stall;

    // event latch and current packet
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_now     <= i_now_time;
            r_tatt    <= i_timer_attempt;
            r_cur_idx <= i_packet_index;
        end else if (i_cmd.pop) begin
            r_cur_idx   <= r_ring[r_head];
            r_from_ring <= 1'b1;
        end else if (i_cmd.take_seq) begin
            r_cur_idx   <= IDX_W'(r_next_seq);
            r_from_ring <= 1'b0;
        end
    end

    // retry ring entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_push) begin
            r_ring[r_tail[RW-1:0]] <= r_cur_idx;
        end
        if (i_cmd.tmo_retry) begin
            r_tail <= (WW+1)'(r_head) + (WW+1)'(r_count);
        end else if (i_cmd.tail_sub) begin
            r_tail <= r_tail - (WW+1)'(win);
        end
    end

    // flow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_count        <= '0;
            r_next_seq     <= '0;
            r_outstanding  <= '0;
            r_nst          <= '0;
            r_wake_pending <= 1'b0;
            r_failed       <= 1'b0;
            r_n            <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_n <= '0;
                if (i_func == FUNC_WAKE) r_wake_pending <= 1'b0;
            end else if (emit_any) begin
                r_n <= r_n + CAP_W'(1);
            end
            if ((i_cmd.ack_upd || i_cmd.tmo_fail || i_cmd.tmo_retry) && leave_dec) begin
                r_outstanding <= r_outstanding - WW'(1);
            end else if (i_cmd.send_emit) begin
                r_outstanding <= r_outstanding + WW'(1);
            end
            if (i_cmd.tmo_fail) r_failed <= 1'b1;
            if (i_cmd.wake_emit) r_wake_pending <= 1'b1;
            if (i_cmd.send_emit) r_nst <= r_now + TIME_W'(i_pacing);
            if (i_cmd.ring_push) begin
                r_count <= r_count + WW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - WW'(1);
                r_head  <= (WW'(r_head) + WW'(1) >= win) ? '0 : r_head + RW'(1);
            end
            if (i_cmd.take_seq) r_next_seq <= r_next_seq + CW'(1);
        end
    end

    // one result held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if ((emit_any || i_cmd.flush) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (emit_any) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((emit_any || i_cmd.flush) && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
        if (emit_any) begin
            r_pend <= new_rec;
        end
    end

    // status
    always_comb begin
        o_stat              = '0;
        o_stat.func         = r_func;
        o_stat.clr_done     = (r_clr_addr == AW'(MAX_PACKETS - 1));
        o_stat.idx_ok       = (32'(r_cur_idx) < 32'(pc));
        o_stat.acked        = acked;
        o_stat.att_match    = (cnt == r_tatt);
        o_stat.failed       = r_failed;
        o_stat.fail_now     = ({1'b0, cnt} + 9'd1 >= {1'b0, i_attempt_limit});
        o_stat.ring_room    = (r_count < win);
        o_stat.tail_ge      = (r_tail >= (WW+1)'(win));
        o_stat.win_full     = (r_outstanding >= win);
        o_stat.at_cap       = (r_n >= CAP_W'(RESULT_CAP));
        o_stat.paced        = (r_now < r_nst);
        o_stat.wake_pending = r_wake_pending;
        o_stat.ring_empty   = (r_count == '0);
        o_stat.seq_done     = (r_next_seq >= pc);
        o_stat.from_ring    = r_from_ring;
        o_stat.can_emit     = !r_pend_valid || out_load_ok;
        o_stat.pend_valid   = r_pend_valid;
        o_stat.can_flush    = out_load_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_out_last  = r_out_last;

endmodule

/* design/wrs_ctrl.sv */
module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  logic              i_div_busy,
    input  t_stat             i_stat,
    output logic              o_in_stall,
    output t_cmd              o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_EV_RD    = 9'b000000100,
        S_EV_CHK   = 9'b000001000,
        S_TAIL     = 9'b000010000,
        S_SEND     = 9'b000100000,
        S_SEND_RD  = 9'b001000000,
        S_SEND_CHK = 9'b010000000,
        S_FLUSH    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_take;

    assign o_in_stall = (r_state != S_IDLE) || i_div_busy;
    assign in_take    = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.accept = 1'b1;
                    if (i_func == FUNC_WAKE) begin
                        n_state = S_SEND;
                    end else if (i_func == FUNC_ACK || i_func == FUNC_TIMER) begin
                        n_state = S_EV_RD;
                    end
                end
            end
            S_EV_RD: begin
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (!i_stat.idx_ok || i_stat.acked) begin
                    n_state = S_IDLE;
                end else if (i_stat.func == FUNC_ACK) begin
                    o_cmd.ack_upd = 1'b1;
                    n_state = S_SEND;
                end else if (!i_stat.att_match || i_stat.failed) begin
                    n_state = S_IDLE;
                end else if (i_stat.fail_now) begin
                    if (i_stat.can_emit) begin
                        o_cmd.tmo_fail = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else begin
                    o_cmd.tmo_retry = 1'b1;
                    n_state = i_stat.ring_room ? S_TAIL : S_SEND;
                end
            end
            // wrap the ring tail into the current window
            S_TAIL: begin
                if (i_stat.tail_ge) begin
                    o_cmd.tail_sub = 1'b1;
                end else begin
                    o_cmd.ring_push = 1'b1;
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (i_stat.failed || i_stat.win_full || i_stat.at_cap) begin
                    n_state = S_FLUSH;
                end else if (i_stat.paced) begin
                    if (i_stat.wake_pending) begin
                        n_state = S_FLUSH;
                    end else if (i_stat.can_emit) begin
                        o_cmd.wake_emit = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else if (!i_stat.ring_empty) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_SEND_RD;
                end else if (i_stat.seq_done) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.take_seq = 1'b1;
                    n_state = S_SEND_RD;
                end
            end
            S_SEND_RD: begin
                n_state = S_SEND_CHK;
            end
            S_SEND_CHK: begin
                if (i_stat.from_ring && (!i_stat.idx_ok || i_stat.acked)) begin
                    n_state = S_SEND;
                end else if (i_stat.can_emit) begin
                    o_cmd.send_emit = 1'b1;
                    n_state = S_SEND;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.can_flush) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/window_retransmit_sender.sv */
// Sender for one windowed flow with timeout retransmission. Events (wake, ack,
// timer expiry) enter one at a time; each produces up to 16 results, the last
// one flagged. After reset the packet store is swept clear, one entry a cycle,
// and a divide works out the packet count; the same divide runs after every
// write of the payload size or flow length register. Input is stalled during
// both. An ack or timer event steps through acceptance, store read and checks
// (a wake skips the store read and checks), then through a selection, a store
// read and a check for each send and for each acked ring entry skipped, a tail
// wrap and push when a timeout queues a retransmission, and a stop and handover
// of the final result; the single-port packet store sets this pace. Output
// stalls hold the block but never lose a transfer.
module window_retransmit_sender
    import wrs_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [TIME_W-1:0]   i_now_time,
    input  logic [IDX_W-1:0]    i_packet_index,
    input  logic [ATT_W-1:0]    i_timer_attempt,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KIND_W-1:0]   o_kind,
    output logic [IDX_W-1:0]    o_send_index,
    output logic [BYTES_W-1:0]  o_send_bytes,
    output logic [ATT_W-1:0]    o_send_attempt,
    output logic [TIME_W-1:0]   o_event_time,
    output logic                o_is_retransmit,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [MTU_W-1:0]     r_mtu;
    logic [FLOW_W-1:0]    r_flow;
    logic [WLIM_W-1:0]    r_wlim;
    logic [PERIOD_W-1:0]  r_pacing;
    logic [PERIOD_W-1:0]  r_timeout;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_div_start;

    logic                 wr_en;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] quot;
    t_cmd                 cmd;
    t_stat                stat;
    t_result              out_rec;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[APB_AW-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu       <= MTU_RST;
            r_flow      <= FLOW_RST;
            r_wlim      <= WLIM_RST;
            r_pacing    <= PACING_RST;
            r_timeout   <= TIMEOUT_RST;
            r_limit     <= LIMIT_RST;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= wr_en && (reg_sel == REG_MTU || reg_sel == REG_FLOW);
            if (wr_en) begin
                case (reg_sel)
                    REG_MTU:     r_mtu     <= pwdata[MTU_W-1:0];
                    REG_FLOW:    r_flow    <= pwdata[FLOW_W-1:0];
                    REG_WINDOW:  r_wlim    <= pwdata[WLIM_W-1:0];
                    REG_PACING:  r_pacing  <= pwdata[PERIOD_W-1:0];
                    REG_TIMEOUT: r_timeout <= pwdata[PERIOD_W-1:0];
                    REG_LIMIT:   r_limit   <= pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // register reads
    always_comb begin
        case (reg_sel)
            REG_MTU:     prdata = APB_DW'(r_mtu);
            REG_FLOW:    prdata = APB_DW'(r_flow);
            REG_WINDOW:  prdata = APB_DW'(r_wlim);
            REG_PACING:  prdata = r_pacing;
            REG_TIMEOUT: prdata = r_timeout;
            REG_LIMIT:   prdata = APB_DW'(r_limit);
            default:     prdata = '0;
        endcase
    end

    wrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_mtu   (r_mtu),
        .i_flow  (r_flow),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    wrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_div_busy (div_busy),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    wrs_datapath #(
        .MAX_PACKETS (MAX_PACKETS),
        .WINDOW_MAX  (WINDOW_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_func),
        .i_now_time      (i_now_time),
        .i_packet_index  (i_packet_index),
        .i_timer_attempt (i_timer_attempt),
        .i_mtu           (r_mtu),
        .i_flow          (r_flow),
        .i_window_limit  (r_wlim),
        .i_pacing        (r_pacing),
        .i_timeout       (r_timeout),
        .i_attempt_limit (r_limit),
        .i_quot          (quot),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out           (out_rec),
        .o_out_last      (o_last)
    );

    assign o_kind          = out_rec.kind;
    assign o_send_index    = out_rec.send_index;
    assign o_send_bytes    = out_rec.send_bytes;
    assign o_send_attempt  = out_rec.send_attempt;
    assign o_event_time    = out_rec.event_time;
    assign o_is_retransmit = out_rec.is_retransmit;

endmodule
